[rtl/srx_pkg.sv]
// Shared types and constants for the shift register output expander.
// No dependencies; used by the top level and by its checker.
package srx_pkg;

    localparam int NUM_BYTES = 8;
    localparam int BYTE_W    = 8;
    localparam int PIN_W     = 6;
    localparam int CHIP_W    = 3;

    typedef logic [BYTE_W-1:0] t_byte;

    // Item kinds.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Pin actions.
    localparam logic [1:0] ACT_OFF    = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHIP_COUNT = 2'd0;
    localparam logic [1:0] CFG_LSB_FIRST  = 2'd1;

    // Result kinds.
    localparam logic ANS_FRAME = 1'b0;
    localparam logic ANS_READ  = 1'b1;

endpackage

[rtl/shift_register_output_expander.sv]
// Top level of the shift register output expander: pin shadow, byte update
// sequencer and serial frame emitter. Depends on srx_pkg.
//
// Channel   Direction  Handshake                     Payload
// command   in         start & !busy                 i_kind i_first_pin i_final_pin i_action
// result    out        o_valid (one cycle, no stall) o_answer_kind o_serial_bit
//                                                    o_pin_level o_frame_end
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index i_cfg_data
//
// A read answers in the cycle after the command transaction, without raising busy.
// An update or clear walks the 8 pin bytes through one byte update unit,
// then sends the clamped chip_count*8 frame bits, one per cycle.
// An empty range or unknown kind finishes at once.
// Reset (synchronous, active low) clears every pin and the registers to
// chip_count 1, lsb_first 0. The receiver cannot stall the result channel.
// Register writes are held off while busy is high.
module shift_register_output_expander #(
    parameter int MAX_CHIPS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  logic [5:0] i_first_pin,
    input  logic [5:0] i_final_pin,
    input  logic [1:0] i_action,
    output logic       o_valid,
    output logic       o_answer_kind,
    output logic       o_serial_bit,
    output logic       o_pin_level,
    output logic       o_frame_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;

    srx_pkg::t_byte r_pins [srx_pkg::NUM_BYTES];
    srx_pkg::t_byte n_byte;

    logic [3:0]                 r_chip_count;
    logic                       r_lsb_first;
    logic [srx_pkg::PIN_W-1:0]  r_first, r_final;
    logic [1:0]                 r_action;
    logic                       r_clear;
    logic [srx_pkg::CHIP_W-1:0] r_chip;
    logic [srx_pkg::PIN_W-1:0]  r_t;

    logic                       n_valid, n_answer_kind, n_serial_bit;
    logic                       n_pin_level, n_frame_end;
    logic [srx_pkg::CHIP_W-1:0] last_chip;
    logic [srx_pkg::PIN_W-1:0]  total_m1;
    logic [srx_pkg::PIN_W-1:0]  bit_idx;
    logic [srx_pkg::PIN_W-1:0]  pin_no;
    srx_pkg::t_byte             mask;
    logic                       accept;
    logic                       cfg_write;
    logic                       read_level;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Number of chips sent, clamped to 1..MAX_CHIPS, held as the highest chip.
    always_comb begin
        if (r_chip_count == 4'd0) begin
            last_chip = '0;
        end else if (r_chip_count > 4'(MAX_CHIPS)) begin
            last_chip = srx_pkg::CHIP_W'(MAX_CHIPS - 1);
        end else begin
            last_chip = srx_pkg::CHIP_W'(r_chip_count - 4'd1);
        end
    end

    assign total_m1 = {last_chip, 3'b111};
    // MSB-first order is the LSB-first index mirrored about the frame length.
    assign bit_idx  = r_lsb_first ? r_t : (total_m1 - r_t);

    assign read_level = r_pins[i_first_pin[5:3]][i_first_pin[2:0]];

    // Shared byte update unit: range mask for the current byte, then action or clear.
    always_comb begin
        for (int b = 0; b < srx_pkg::BYTE_W; b++) begin
            pin_no  = {r_chip, 3'(b)};
            mask[b] = (pin_no >= r_first) && (pin_no <= r_final);
        end
        if (r_clear) begin
            n_byte = '0;
        end else begin
            case (r_action)
                srx_pkg::ACT_OFF:    n_byte = r_pins[r_chip] & ~mask;
                srx_pkg::ACT_ON:     n_byte = r_pins[r_chip] | mask;
                srx_pkg::ACT_TOGGLE: n_byte = r_pins[r_chip] ^ mask;
                default:             n_byte = r_pins[r_chip];
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_valid       = 1'b0;
        n_answer_kind = srx_pkg::ANS_FRAME;
        n_serial_bit  = 1'b0;
        n_pin_level   = 1'b0;
        n_frame_end   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == srx_pkg::KIND_READ) begin
                        n_valid       = 1'b1;
                        n_answer_kind = srx_pkg::ANS_READ;
                        n_pin_level   = read_level;
                        n_frame_end   = 1'b1;
                    end else if (i_kind == srx_pkg::KIND_CLEAR) begin
                        n_state = ST_UPDATE;
                    end else if (i_kind == srx_pkg::KIND_UPDATE
                                 && i_final_pin >= i_first_pin) begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (r_chip == srx_pkg::CHIP_W'(srx_pkg::NUM_BYTES - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_valid      = 1'b1;
                n_serial_bit = r_pins[bit_idx[5:3]][bit_idx[2:0]];
                if (r_t == total_m1) begin
                    n_frame_end = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_chip_count  <= 4'd1;
            r_lsb_first   <= 1'b0;
            r_chip        <= '0;
            r_t           <= '0;
            o_valid       <= 1'b0;
            o_answer_kind <= 1'b0;
            o_serial_bit  <= 1'b0;
            o_pin_level   <= 1'b0;
            o_frame_end   <= 1'b0;
            for (int i = 0; i < srx_pkg::NUM_BYTES; i++) begin
                r_pins[i] <= '0;
            end
        end else begin
            r_state       <= n_state;
            o_valid       <= n_valid;
            o_answer_kind <= n_answer_kind;
            o_serial_bit  <= n_serial_bit;
            o_pin_level   <= n_pin_level;
            o_frame_end   <= n_frame_end;

            if (cfg_write) begin
                unique case (i_cfg_index)
                    srx_pkg::CFG_CHIP_COUNT: r_chip_count <= i_cfg_data;
                    srx_pkg::CFG_LSB_FIRST:  r_lsb_first  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_first  <= i_first_pin;
                r_final  <= i_final_pin;
                r_action <= i_action;
                r_clear  <= (i_kind == srx_pkg::KIND_CLEAR);
                r_chip   <= '0;
                r_t      <= '0;
            end

            if (r_state == ST_UPDATE) begin
                r_pins[r_chip] <= n_byte;
                r_chip         <= r_chip + srx_pkg::CHIP_W'(1);
            end

            if (r_state == ST_EMIT) begin
                r_t <= r_t + srx_pkg::PIN_W'(1);
            end
        end
    end

endmodule

[rtl/srx_checker.sv]
// Port-level checker for the shift register output expander, with its bind.
// Depends on srx_pkg and on the top level's ports.
module srx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_kind,
    input logic       o_valid,
    input logic       o_answer_kind,
    input logic       o_serial_bit,
    input logic       o_pin_level,
    input logic       o_frame_end
);

    // A read answer is a single transaction that also closes its own frame.
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_answer_kind == srx_pkg::ANS_READ) |-> (o_frame_end && !o_serial_bit))
        else $error("read answer without frame end or with data bit");

    a_frame_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_answer_kind == srx_pkg::ANS_FRAME) |-> !o_pin_level)
        else $error("frame bit carries a pin level");

    // Frame bits come in an unbroken run until the marked last bit.
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_answer_kind == srx_pkg::ANS_FRAME && !o_frame_end)
        |=> (o_valid && o_answer_kind == srx_pkg::ANS_FRAME))
        else $error("frame broken before its last bit");

    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == srx_pkg::KIND_READ)
        |=> (o_valid && o_answer_kind == srx_pkg::ANS_READ && !busy))
        else $error("read command not answered in the next cycle");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == srx_pkg::KIND_CLEAR) |=> busy)
        else $error("clear command did not start a sequence");

endmodule

bind shift_register_output_expander srx_checker u_srx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_valid       (o_valid),
    .o_answer_kind (o_answer_kind),
    .o_serial_bit  (o_serial_bit),
    .o_pin_level   (o_pin_level),
    .o_frame_end   (o_frame_end)
);
